>>> sv/jrli_pkg.sv
// ----------------------------------------------------------------------------
// JPEG restart line indexer - shared package
// Widths, register map, marker codes, shared types and the entry address sum.
// ----------------------------------------------------------------------------
package jrli_pkg;

	// Datapath widths
	localparam int ADDR_BITS     = 24;
	localparam int LINE_BITS     = 16;
	localparam int BYTE_BITS     = 8;
	localparam int STRIDE_BITS   = 8;
	localparam int PROD_BITS     = STRIDE_BITS + LINE_BITS;
	localparam int SUM_BITS      = ADDR_BITS + PROD_BITS;

	// APB port
	localparam int APB_ADDR_BITS = 4;
	localparam int APB_DATA_BITS = 32;

	// Register reset values
	localparam logic [STRIDE_BITS-1:0] STRIDE_RESET = 8'd16;

	// Marker codes: first byte, end of image, restart prefix (FFD0..FFD7)
	localparam logic [BYTE_BITS-1:0] MARKER_PREFIX = 8'hFF;
	localparam logic [BYTE_BITS-1:0] EOI_CODE      = 8'hD9;
	localparam logic [4:0]           RST_CODE_HI   = 5'b11010;

	// Register indexes (byte address = 4 * index)
	typedef enum logic [1:0] {
		REG_IMAGE_BASE,
		REG_INDEX_BASE,
		REG_ENTRY_STRIDE
	} reg_idx_t;

	// Configuration register set
	typedef struct packed {
		logic [ADDR_BITS-1:0]   image_base;
		logic [ADDR_BITS-1:0]   index_base;
		logic [STRIDE_BITS-1:0] entry_stride;
	} cfg_t;

	// One index entry
	typedef struct packed {
		logic [LINE_BITS-1:0] line_number;
		logic [ADDR_BITS-1:0] start_address;
		logic [ADDR_BITS-1:0] end_address;
		logic [ADDR_BITS-1:0] entry_address;
		logic                 image_end;
	} entry_t;

	// index_base + stride * line, wrapped to the address width
	function automatic logic [ADDR_BITS-1:0] entry_addr(
		input logic [ADDR_BITS-1:0]   base,
		input logic [STRIDE_BITS-1:0] stride,
		input logic [LINE_BITS-1:0]   line
	);
		logic [PROD_BITS-1:0] prod;
		logic [SUM_BITS-1:0]  sum;
		prod = PROD_BITS'(stride) * PROD_BITS'(line);
		sum  = SUM_BITS'(base) + SUM_BITS'(prod);
		return sum[ADDR_BITS-1:0];
	endfunction

endpackage

>>> sv/jrli_if.sv
// ----------------------------------------------------------------------------
// JPEG restart line indexer - channel interfaces
// Valid/ready channels for image bytes and for index entries.
// ----------------------------------------------------------------------------

// Image byte channel
interface jrli_byte_if;
	logic                          valid;
	logic                          ready;
	logic [jrli_pkg::BYTE_BITS-1:0] data_byte;

	modport source(output valid, output data_byte, input ready);
	modport sink(input valid, input data_byte, output ready);
endinterface

// Index entry channel
interface jrli_entry_if;
	logic                           valid;
	logic                           ready;
	logic [jrli_pkg::LINE_BITS-1:0] line_number;
	logic [jrli_pkg::ADDR_BITS-1:0] start_address;
	logic [jrli_pkg::ADDR_BITS-1:0] end_address;
	logic [jrli_pkg::ADDR_BITS-1:0] entry_address;
	logic                           image_end;

	modport source(output valid, output line_number, output start_address,
		output end_address, output entry_address, output image_end, input ready);
	modport sink(input valid, input line_number, input start_address,
		input end_address, input entry_address, input image_end, output ready);
endinterface

>>> sv/jrli_core.sv
// ----------------------------------------------------------------------------
// JPEG restart line indexer - marker scanner core
// Holds the scan state, spots FFD0..FFD7 and FFD9 across byte pairs, resyncs
// the line counter and forms the index entry for the output register.
// ----------------------------------------------------------------------------
module jrli_core (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            step,
	input  logic [jrli_pkg::BYTE_BITS-1:0]  data_byte,
	input  jrli_pkg::cfg_t                  cfg,
	input  logic                            base_wr,
	input  logic [jrli_pkg::ADDR_BITS-1:0]  base_val,
	output logic                            emit,
	output jrli_pkg::entry_t                res
);

	localparam int LB = jrli_pkg::LINE_BITS;

	logic [jrli_pkg::BYTE_BITS-1:0] prev_q, prev_d;
	logic                           have_q, have_d;
	logic [jrli_pkg::ADDR_BITS-1:0] addr_q, addr_d;
	logic [jrli_pkg::ADDR_BITS-1:0] lstart_q, lstart_d;
	logic [LB-1:0]                  cnt_q, cnt_d;

	logic                           is_eoi;
	logic                           is_rst;
	logic [2:0]                     rcount;
	logic [LB-1:0]                  synced;
	logic [jrli_pkg::ADDR_BITS-1:0] addr_inc;

	// Marker decode on the byte pair
	assign is_eoi   = have_q && (prev_q == jrli_pkg::MARKER_PREFIX)
		&& (data_byte == jrli_pkg::EOI_CODE);
	assign is_rst   = have_q && (prev_q == jrli_pkg::MARKER_PREFIX)
		&& (data_byte[7:3] == jrli_pkg::RST_CODE_HI);
	assign rcount   = data_byte[2:0];
	assign addr_inc = addr_q + jrli_pkg::ADDR_BITS'(1);

	// Resync: next counter value whose low three bits match the marker count
	always_comb begin
		if (cnt_q[2:0] == rcount) begin
			synced = cnt_q;
		end else if (cnt_q[2:0] < rcount) begin
			synced = {cnt_q[LB-1:3], rcount};
		end else begin
			synced = {cnt_q[LB-1:3] + (LB-3)'(1), rcount};
		end
	end

	// Entry forming
	always_comb begin
		emit              = step && (is_eoi || is_rst);
		res.line_number   = is_eoi ? cnt_q : synced;
		res.start_address = lstart_q;
		res.end_address   = addr_q;
		res.image_end     = is_eoi;
		res.entry_address = jrli_pkg::entry_addr(cfg.index_base, cfg.entry_stride,
			res.line_number);
	end

	// Next scan state
	always_comb begin
		prev_d   = prev_q;
		have_d   = have_q;
		addr_d   = addr_q;
		lstart_d = lstart_q;
		cnt_d    = cnt_q;
		if (step) begin
			addr_d = addr_inc;
			prev_d = data_byte;
			have_d = 1'b1;
			if (is_eoi) begin
				// back to the start state for the next image
				prev_d   = '0;
				have_d   = 1'b0;
				addr_d   = cfg.image_base;
				lstart_d = cfg.image_base;
				cnt_d    = '0;
			end else if (is_rst) begin
				lstart_d = addr_inc;
				cnt_d    = synced + LB'(1);
			end
		end else if (base_wr && !have_q) begin
			// new base takes effect at once between images
			addr_d   = base_val;
			lstart_d = base_val;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q   <= '0;
			have_q   <= 1'b0;
			addr_q   <= '0;
			lstart_q <= '0;
			cnt_q    <= '0;
		end else begin
			prev_q   <= prev_d;
			have_q   <= have_d;
			addr_q   <= addr_d;
			lstart_q <= lstart_d;
			cnt_q    <= cnt_d;
		end
	end

endmodule

>>> sv/jpeg_restart_line_indexer_unit.sv
// ----------------------------------------------------------------------------
// JPEG restart line indexer - top level
// Scans a JPEG byte stream for restart and end-of-image markers and emits one
// line index entry per marker. APB register port for the table set-up.
// ----------------------------------------------------------------------------
// Takes one image byte per clock and gives an index entry for the byte that
// completes a restart (FFD0..FFD7) or end-of-image (FFD9) marker; other
// bytes give no entry. A byte goes into an input register, the marker
// decode, counter resync and the 8x16 entry address multiply-add run
// combinationally from there into the output register. A new byte is taken
// every cycle as long as the output register is empty or being drained; a
// stalled entry holds at most one further byte in the input register.
// Registers: image_base at 0x0, index_base at 0x4, entry_stride at 0x8.
module jpeg_restart_line_indexer_unit (
	input  logic                               clk,
	input  logic                               arst_n,
	jrli_byte_if.sink                          bytes,
	jrli_entry_if.source                       entries,
	input  logic                               psel,
	input  logic                               penable,
	input  logic                               pwrite,
	input  logic [jrli_pkg::APB_ADDR_BITS-1:0] paddr,
	input  logic [jrli_pkg::APB_DATA_BITS-1:0] pwdata,
	output logic [jrli_pkg::APB_DATA_BITS-1:0] prdata,
	output logic                               pready
);

	jrli_pkg::cfg_t     cfg_q;
	jrli_pkg::reg_idx_t reg_idx;
	logic               wr_en;
	logic               base_wr;

	logic                           valid_s1;
	logic [jrli_pkg::BYTE_BITS-1:0] byte_s1;
	logic                           advance;

	logic                           core_emit;
	jrli_pkg::entry_t               core_res;
	logic                           out_valid_q;
	jrli_pkg::entry_t               entry_q;

	// APB register port
	assign pready  = 1'b1;
	assign reg_idx = jrli_pkg::reg_idx_t'(paddr[jrli_pkg::APB_ADDR_BITS-1:2]);
	assign wr_en   = psel && penable && pwrite;
	assign base_wr = wr_en && (reg_idx == jrli_pkg::REG_IMAGE_BASE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.image_base   <= '0;
			cfg_q.index_base   <= '0;
			cfg_q.entry_stride <= jrli_pkg::STRIDE_RESET;
		end else if (wr_en) begin
			case (reg_idx)
				jrli_pkg::REG_IMAGE_BASE:
					cfg_q.image_base <= pwdata[jrli_pkg::ADDR_BITS-1:0];
				jrli_pkg::REG_INDEX_BASE:
					cfg_q.index_base <= pwdata[jrli_pkg::ADDR_BITS-1:0];
				jrli_pkg::REG_ENTRY_STRIDE:
					cfg_q.entry_stride <= pwdata[jrli_pkg::STRIDE_BITS-1:0];
				default: ;
			endcase
		end
	end

	// Register readback
	always_comb begin
		case (reg_idx)
			jrli_pkg::REG_IMAGE_BASE:
				prdata = jrli_pkg::APB_DATA_BITS'(cfg_q.image_base);
			jrli_pkg::REG_INDEX_BASE:
				prdata = jrli_pkg::APB_DATA_BITS'(cfg_q.index_base);
			jrli_pkg::REG_ENTRY_STRIDE:
				prdata = jrli_pkg::APB_DATA_BITS'(cfg_q.entry_stride);
			default:
				prdata = '0;
		endcase
	end

	// Input register; it moves on whenever the output register can take a result
	assign advance     = valid_s1 && (!out_valid_q || entries.ready);
	assign bytes.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (bytes.ready) begin
			valid_s1 <= bytes.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (bytes.valid && bytes.ready) begin
			byte_s1 <= bytes.data_byte;
		end
	end

	jrli_core u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (advance),
		.data_byte (byte_s1),
		.cfg       (cfg_q),
		.base_wr   (base_wr),
		.base_val  (pwdata[jrli_pkg::ADDR_BITS-1:0]),
		.emit      (core_emit),
		.res       (core_res)
	);

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= core_emit;
		end else if (entries.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (core_emit) begin
			entry_q <= core_res;
		end
	end

	assign entries.valid         = out_valid_q;
	assign entries.line_number   = entry_q.line_number;
	assign entries.start_address = entry_q.start_address;
	assign entries.end_address   = entry_q.end_address;
	assign entries.entry_address = entry_q.entry_address;
	assign entries.image_end     = entry_q.image_end;

endmodule

>>> sv/jrli_checker.sv
// ----------------------------------------------------------------------------
// JPEG restart line indexer - port checker
// Watches the top level's ports over time; bound to the top level below.
// ----------------------------------------------------------------------------
module jrli_checker (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           in_valid,
	input logic                           in_ready,
	input logic                           out_valid,
	input logic                           out_ready,
	input logic [jrli_pkg::LINE_BITS-1:0] out_line,
	input logic [jrli_pkg::ADDR_BITS-1:0] out_end,
	input logic                           out_eoi,
	input logic                           pready
);

	// A stalled entry holds its payload
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_line)
			&& $stable(out_end) && $stable(out_eoi))
		else $error("entry changed while stalled");

	// A fresh entry has a byte transaction behind it
	a_out_cause: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid) |-> $past(in_valid && in_ready, 2))
		else $error("entry without a byte transaction behind it");

	// With the output empty, the byte side never stalls
	a_in_free: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("byte side stalled with empty output");

	// Register port never inserts wait states
	a_pready: assert property (@(posedge clk) disable iff (!arst_n)
		pready)
		else $error("pready low");

endmodule

bind jpeg_restart_line_indexer_unit jrli_checker u_jrli_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (bytes.valid),
	.in_ready  (bytes.ready),
	.out_valid (entries.valid),
	.out_ready (entries.ready),
	.out_line  (entries.line_number),
	.out_end   (entries.end_address),
	.out_eoi   (entries.image_end),
	.pready    (pready)
);

>>> test/tb_jpeg_restart_line_indexer_unit.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Testbench for jpeg_restart_line_indexer_unit
// Sends JPEG-like byte streams through the byte channel and checks every index
// entry against a line index predictor held in a scoreboard class. The run
// covers marker decode, counter resync, address wrap and register changes
// over the APB port. Both channels idle at random in most settings.
// ----------------------------------------------------------------------------
module tb_jpeg_restart_line_indexer_unit;

	localparam int TIMEOUT_NS        = 2_000_000;
	localparam int DRAIN_CYCLES      = 8;
	localparam int ITEMS_PER_SETTING = 300;
	localparam int N_SETTINGS        = 6;

	// Codes that resemble markers but must be ignored
	localparam logic [jrli_pkg::BYTE_BITS-1:0] SOI_CODE    = 8'hD8;
	localparam logic [4:0]                     FAKE_RST_HI = 5'b11110;

	// Unused register slot, writes are dropped
	localparam logic [jrli_pkg::APB_ADDR_BITS-1:0] SPARE_REG_ADDR = 4'hC;

	// ------------------------------------------------------------------------
	// Line index predictor and store of expected entries
	// ------------------------------------------------------------------------
	class line_index_scoreboard;
		jrli_pkg::cfg_t                 regs;
		logic [jrli_pkg::BYTE_BITS-1:0] prev_byte;
		bit                             pair_open;
		logic [jrli_pkg::ADDR_BITS-1:0] next_addr;
		logic [jrli_pkg::ADDR_BITS-1:0] line_begin;
		logic [jrli_pkg::LINE_BITS-1:0] line_no;
		jrli_pkg::entry_t               expected_entries[$];
		int unsigned                    n_bytes, n_restart, n_eoi, n_errors;

		function new();
			regs.image_base   = '0;
			regs.index_base   = '0;
			regs.entry_stride = jrli_pkg::STRIDE_RESET;
			new_image();
		endfunction

		function void new_image();
			prev_byte  = '0;
			pair_open  = 1'b0;
			next_addr  = regs.image_base;
			line_begin = regs.image_base;
			line_no    = '0;
		endfunction

		function void write_reg(logic [jrli_pkg::APB_ADDR_BITS-1:0] addr,
			logic [jrli_pkg::APB_DATA_BITS-1:0] data);
			case (addr[jrli_pkg::APB_ADDR_BITS-1:2])
				jrli_pkg::REG_IMAGE_BASE: begin
					regs.image_base = data[jrli_pkg::ADDR_BITS-1:0];
					// takes effect at once only before the image's first byte
					if (!pair_open) begin
						next_addr  = regs.image_base;
						line_begin = regs.image_base;
					end
				end
				jrli_pkg::REG_INDEX_BASE:
					regs.index_base   = data[jrli_pkg::ADDR_BITS-1:0];
				jrli_pkg::REG_ENTRY_STRIDE:
					regs.entry_stride = data[jrli_pkg::STRIDE_BITS-1:0];
				default: ;
			endcase
		endfunction

		function jrli_pkg::entry_t make_entry(logic [jrli_pkg::LINE_BITS-1:0] line,
			logic [jrli_pkg::ADDR_BITS-1:0] mark_addr, logic eoi);
			logic [jrli_pkg::SUM_BITS-1:0] total;
			jrli_pkg::entry_t              e;
			total = jrli_pkg::SUM_BITS'(regs.index_base) +
				jrli_pkg::SUM_BITS'(regs.entry_stride) * jrli_pkg::SUM_BITS'(line);
			e.line_number   = line;
			e.start_address = line_begin;
			e.end_address   = mark_addr;
			e.entry_address = total[jrli_pkg::ADDR_BITS-1:0];
			e.image_end     = eoi;
			return e;
		endfunction

		function void note_byte(logic [jrli_pkg::BYTE_BITS-1:0] b);
			logic [jrli_pkg::ADDR_BITS-1:0]   here;
			logic [2*jrli_pkg::BYTE_BITS-1:0] pair;
			here      = next_addr;
			next_addr = here + jrli_pkg::ADDR_BITS'(1);
			n_bytes++;
			if (!pair_open) begin
				prev_byte = b;
				pair_open = 1'b1;
				return;
			end
			pair      = {prev_byte, b};
			prev_byte = b;
			if (pair == {jrli_pkg::MARKER_PREFIX, jrli_pkg::EOI_CODE}) begin
				expected_entries.push_back(make_entry(line_no, here, 1'b1));
				new_image();
			end else if (pair[15:8] == jrli_pkg::MARKER_PREFIX
				&& pair[7:3] == jrli_pkg::RST_CODE_HI) begin
				// resync: move up to the next count whose low bits match the marker
				line_no = {line_no[jrli_pkg::LINE_BITS-1:3], b[2:0]} +
					((b[2:0] < line_no[2:0]) ? jrli_pkg::LINE_BITS'(8)
						: jrli_pkg::LINE_BITS'(0));
				expected_entries.push_back(make_entry(line_no, here, 1'b0));
				line_begin = here + jrli_pkg::ADDR_BITS'(1);
				line_no    = line_no + jrli_pkg::LINE_BITS'(1);
			end
		endfunction

		function void cmp(string field, logic [31:0] want, logic [31:0] got);
			if (want !== got) begin
				$error("%s: expected 0x%0h, got 0x%0h", field, want, got);
				n_errors++;
			end
		endfunction

		function void check_entry(jrli_pkg::entry_t got);
			jrli_pkg::entry_t want;
			if (expected_entries.size() == 0) begin
				$error("entry with none expected: line 0x%0h end 0x%0h", got.line_number,
					got.end_address);
				n_errors++;
				return;
			end
			want = expected_entries.pop_front();
			if (want.image_end) n_eoi++;
			else n_restart++;
			cmp("line_number", 32'(want.line_number), 32'(got.line_number));
			cmp("start_address", 32'(want.start_address), 32'(got.start_address));
			cmp("end_address", 32'(want.end_address), 32'(got.end_address));
			cmp("entry_address", 32'(want.entry_address), 32'(got.entry_address));
			cmp("image_end", 32'(want.image_end), 32'(got.image_end));
		endfunction

		function int pending();
			return expected_entries.size();
		endfunction
	endclass

	// ------------------------------------------------------------------------
	// Clock, signals and DUT
	// ------------------------------------------------------------------------
	logic                               clk = 1'b0;
	logic                               arst_n;
	logic                               psel, penable, pwrite;
	logic [jrli_pkg::APB_ADDR_BITS-1:0] paddr;
	logic [jrli_pkg::APB_DATA_BITS-1:0] pwdata;
	logic [jrli_pkg::APB_DATA_BITS-1:0] prdata;
	logic                               pready;

	int unsigned send_idle_pct;
	int unsigned recv_stall_pct;

	line_index_scoreboard sb;

	jrli_byte_if  byte_ch();
	jrli_entry_if entry_ch();

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	jpeg_restart_line_indexer_unit i_dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.bytes   (byte_ch),
		.entries (entry_ch),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	// Entry receiver back-pressure
	always @(posedge clk) begin
		entry_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
	end

	// Transaction monitor: at the falling edge the values are those that the
	// next rising edge will take
	always @(negedge clk) begin
		if (arst_n) begin
			if (byte_ch.valid && byte_ch.ready)
				sb.note_byte(byte_ch.data_byte);
			if (entry_ch.valid && entry_ch.ready)
				sb.check_entry(jrli_pkg::entry_t'({entry_ch.line_number,
					entry_ch.start_address, entry_ch.end_address,
					entry_ch.entry_address, entry_ch.image_end}));
		end
	end

	// Run limit, well above the slowest legal run
	initial begin
		#(TIMEOUT_NS);
		$display("jpeg_restart_line_indexer_unit: mismatch");
		$finish;
	end

	// ------------------------------------------------------------------------
	// Drivers
	// ------------------------------------------------------------------------
	function automatic logic [jrli_pkg::BYTE_BITS-1:0] rst_code(logic [2:0] count);
		return {jrli_pkg::RST_CODE_HI, count};
	endfunction

	// Byte biased towards marker and marker-like codes
	function automatic logic [jrli_pkg::BYTE_BITS-1:0] noise_byte();
		case ($urandom_range(9))
			0, 1:    return jrli_pkg::MARKER_PREFIX;
			2:       return rst_code(3'($urandom_range(7)));
			3:       return {FAKE_RST_HI, 3'($urandom_range(7))};
			4:       return SOI_CODE;
			5:       return jrli_pkg::EOI_CODE;
			default: return 8'($urandom_range(255));
		endcase
	endfunction

	task automatic send_byte(input logic [jrli_pkg::BYTE_BITS-1:0] b);
		while ($urandom_range(99) < send_idle_pct) begin
			byte_ch.valid <= 1'b0;
			@(posedge clk);
		end
		byte_ch.valid     <= 1'b1;
		byte_ch.data_byte <= b;
		do @(negedge clk); while (!byte_ch.ready);
		@(posedge clk);
	endtask

	// Stop the byte stream and wait until every entry is out
	task automatic drain();
		byte_ch.valid <= 1'b0;
		while (sb.pending() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic apb_write(input logic [jrli_pkg::APB_ADDR_BITS-1:0] addr,
		input logic [jrli_pkg::APB_DATA_BITS-1:0] data);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= addr;
		pwdata  <= data;
		@(posedge clk);
		penable <= 1'b1;
		do @(negedge clk); while (!pready);
		@(posedge clk);
		sb.write_reg(addr, data);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(posedge clk);
	endtask

	// Register settings, mostly extremes; upper data bits are junk on purpose
	task automatic configure(input int unsigned setting);
		logic [jrli_pkg::ADDR_BITS-1:0]   img, idx;
		logic [jrli_pkg::STRIDE_BITS-1:0] stride;
		img    = 24'($urandom);
		idx    = 24'($urandom);
		stride = 8'($urandom_range(254, 1));
		case (setting)
			0: begin img = 24'hFFFFF8; idx = '0;         stride = 8'd1;   end
			1: begin                                     stride = 8'd0;   end
			2: begin img = '0;         idx = 24'hFFFFFF; stride = 8'd255; end
			4: begin img = 24'hFFFFFF; idx = 24'hFFFF00; stride = 8'd255; end
			5: begin img = 24'hFFFFF0; idx = 24'hFFFFF0; stride = 8'd255; end
			default: ;
		endcase
		apb_write({jrli_pkg::REG_INDEX_BASE, 2'b00}, {8'($urandom), idx});
		apb_write({jrli_pkg::REG_ENTRY_STRIDE, 2'b00}, {24'($urandom), stride});
		apb_write({jrli_pkg::REG_IMAGE_BASE, 2'b00}, {8'($urandom), img});
		if (setting == 1)
			apb_write(SPARE_REG_ADDR, $urandom);
	endtask

	// Short directed stream under the reset register values
	task automatic send_directed();
		logic [jrli_pkg::BYTE_BITS-1:0] seq[$];
		seq = {
			8'h00,                                           // lone first byte
			jrli_pkg::MARKER_PREFIX, rst_code(3'd0),         // in step
			jrli_pkg::MARKER_PREFIX, rst_code(3'd3),         // skips lines forward
			jrli_pkg::MARKER_PREFIX, rst_code(3'd1),         // count below low bits
			jrli_pkg::MARKER_PREFIX, SOI_CODE,               // not a restart
			jrli_pkg::MARKER_PREFIX, {FAKE_RST_HI, 3'd5},    // not a restart
			jrli_pkg::MARKER_PREFIX, rst_code(3'd7),
			jrli_pkg::MARKER_PREFIX, jrli_pkg::MARKER_PREFIX, rst_code(3'd2),
			8'h00, jrli_pkg::MARKER_PREFIX, jrli_pkg::EOI_CODE, // end of image
			rst_code(3'd4),                                  // next image's first byte
			jrli_pkg::MARKER_PREFIX, rst_code(3'd4),
			jrli_pkg::MARKER_PREFIX, jrli_pkg::EOI_CODE
		};
		foreach (seq[k]) send_byte(seq[k]);
	endtask

	// Mostly well-formed images with random bodies, some noise bursts
	task automatic send_random_stream(input int unsigned n_items);
		int unsigned sent, lines, body;
		logic [2:0]  count;
		sent = 0;
		while (sent < n_items) begin
			if ($urandom_range(99) < 75) begin
				lines = $urandom_range(6, 1);
				repeat (lines) begin
					body = $urandom_range(12);
					repeat (body) send_byte(8'($urandom_range(255)));
					// usually the count that follows, sometimes a skip
					count = ($urandom_range(99) < 80) ? sb.line_no[2:0] : 3'($urandom_range(7));
					send_byte(jrli_pkg::MARKER_PREFIX);
					send_byte(rst_code(count));
					sent += body + 2;
				end
				if ($urandom_range(99) < 85) begin
					send_byte(jrli_pkg::MARKER_PREFIX);
					send_byte(jrli_pkg::EOI_CODE);
					sent += 2;
				end
			end else begin
				body = $urandom_range(20, 1);
				repeat (body) send_byte(noise_byte());
				sent += body;
			end
		end
	endtask

	// ------------------------------------------------------------------------
	// Test sequence
	// ------------------------------------------------------------------------
	initial begin
		sb                = new();
		arst_n            = 1'b0;
		psel              = 1'b0;
		penable           = 1'b0;
		pwrite            = 1'b0;
		paddr             = '0;
		pwdata            = '0;
		byte_ch.valid     = 1'b0;
		byte_ch.data_byte = '0;
		entry_ch.ready    = 1'b0;
		send_idle_pct     = 31;
		recv_stall_pct    = 81;

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_directed();
		drain();

		// two register settings per idling pattern
		for (int s = 0; s < N_SETTINGS; s++) begin
			case (s / 2)
				0:       begin send_idle_pct = 31; recv_stall_pct = 81; end
				1:       begin send_idle_pct = 81; recv_stall_pct = 31; end
				default: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
			endcase
			configure(s);
			send_random_stream(ITEMS_PER_SETTING);
			drain();
		end

		$display("Sent %0d bytes over %0d register settings", sb.n_bytes, N_SETTINGS);
		$display("Checked %0d restart and %0d end-of-image entries, with address wrap and zero stride",
			sb.n_restart, sb.n_eoi);
		if (sb.n_errors == 0)
			$display("jpeg_restart_line_indexer_unit: match");
		else
			$display("jpeg_restart_line_indexer_unit: mismatch");
		$finish;
	end

endmodule
